// ===== design/msdr_pkg.sv =====
// shared types and constants of the stock-directory resolver
// no dependencies; imported by every module of the block
package msdr_pkg;

  localparam int LOC_W        = 16;
  localparam int LOCATE_SPACE = 1 << LOC_W;
  localparam int SYM_W        = 64;
  localparam int CAT_W        = 8;
  localparam int LOT_W        = 32;
  localparam int ATTR_W       = 2 * CAT_W + LOT_W + 1;
  localparam int SLOTS        = 6;
  localparam int SLOT_W       = 3;
  localparam int SYMTAB_DEPTH = 16384;
  localparam int SYMTAB_AW    = 14;
  localparam int FILL_W       = SYMTAB_AW + 1;
  localparam int IN_W         = LOC_W + SYM_W + 3 * CAT_W + LOT_W;
  localparam int STATUS_W     = 4;
  localparam int OUT_W        = 8;
  localparam int CFG_AW       = 3;
  localparam int CFG_W        = 64;

  localparam logic [7:0] PAD_BYTE  = 8'h20;
  localparam logic [7:0] TOP_PRINT = 8'h7e;
  localparam logic [7:0] CHAR_Y    = 8'h59;
  localparam logic [7:0] CHAR_N    = 8'h4e;

  localparam logic [CFG_AW-1:0] REG_COUNT = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SYM0  = 3'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW          = 4'd0,
    ST_REPEAT       = 4'd1,
    ST_SELECTED     = 4'd2,
    ST_RESERVED     = 4'd3,
    ST_BAD_SYM      = 4'd4,
    ST_BAD_FLAG     = 4'd5,
    ST_LOC_CONFLICT = 4'd6,
    ST_SYM_CONFLICT = 4'd7,
    ST_FULL         = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOC, S_RD, S_CMP, S_INS, S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic scan_start;
    logic scan_rd;
    logic scan_next;
    logic scan_found;
    logic take_early;
    logic take_conflict;
    logic take_full;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic early_done;
    logic scan_end;
    logic scan_hit;
    logic scan_loc_eq;
    logic full_block;
    logic out_free;
  } stat_t;

endpackage

// ===== design/market_symbol_directory_resolver.sv =====
// top level of the stock-directory resolver
// depends on msdr_pkg, msdr_ctrl and msdr_datapath
//
//  channel  dir  beat contents (lowest bits first)
//  in_      in   locate 16, symbol 64, category 8,
//                fin state 8, lot size 32, lots flag 8
//  out_     out  status 4, resolved_slot 3, all_resolved 1
//  cfg_     in   index 0 requested_count, 1..6 requested_symbol_0..5
//
// one record at a time; a rejected record or a repeat is settled by the locate
// check, a new locate also runs the linear scan of the symbol table memory,
// which reads and then compares one entry at a time
// after reset a clearing pass over all 65536 locates empties the locate-known store;
// no beat is taken meanwhile, configuration writes are taken as ever
// the result register holds a beat until taken; a stalled result holds
// the block in its done state
module market_symbol_directory_resolver import msdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // locate, symbol, category, status, lot, flag
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // status, resolved_slot, all_resolved
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cmd_t  cmd;   // controller to datapath
  stat_t stat;  // datapath to controller

  msdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msdr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== design/msdr_ctrl.sv =====
// controller state machine of the stock-directory resolver
// depends on msdr_pkg; drives msdr_datapath through cmd_t
module msdr_ctrl import msdr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_LOC;
      S_LOC:   state_nxt = stat.early_done ? S_DONE : S_RD;
      S_RD:    state_nxt = stat.scan_end ? S_INS : S_CMP;
      S_CMP: begin
        if (stat.scan_hit) state_nxt = stat.scan_loc_eq ? S_INS : S_DONE;
        else state_nxt = S_RD;
      end
      S_INS:   state_nxt = S_DONE;
      S_DONE:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_LOC: begin
        cmd.take_early = stat.early_done;
        cmd.scan_start = !stat.early_done;
      end
      S_RD: cmd.scan_rd = !stat.scan_end;
      S_CMP: begin
        cmd.scan_found    = stat.scan_hit && stat.scan_loc_eq;
        cmd.take_conflict = stat.scan_hit && !stat.scan_loc_eq;
        cmd.scan_next     = !stat.scan_hit;
      end
      S_INS: begin
        cmd.take_full = stat.full_block;
        cmd.commit    = !stat.full_block;
      end
      S_DONE: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/msdr_datapath.sv =====
// datapath of the stock-directory resolver: record checks, locate store,
// symbol table, requested slots and the result register; depends on msdr_pkg
module msdr_datapath import msdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [OUT_W-1:0]  out_tdata,
  input  cmd_t              cmd,
  output stat_t             stat
);

  // captured record
  logic [LOC_W-1:0] loc_r;
  logic [SYM_W-1:0] sym_r;
  logic [CAT_W-1:0] cat_r, fin_r, flag_r;
  logic [LOT_W-1:0] lot_r;

  // configuration
  logic [SLOT_W-1:0] count_r;
  logic [SYM_W-1:0]  req_r [SLOTS];
  logic [SLOTS-1:0]  resolved_r;

  // memories
  logic              known_mem [LOCATE_SPACE];
  logic [SYM_W-1:0]  lsym_mem  [LOCATE_SPACE];
  logic [ATTR_W-1:0] lattr_mem [LOCATE_SPACE];
  logic [SYM_W-1:0]  key_mem   [SYMTAB_DEPTH];
  logic [LOC_W-1:0]  sloc_mem  [SYMTAB_DEPTH];

  logic              known_rd_r;
  logic [SYM_W-1:0]  lsym_rd_r;
  logic [ATTR_W-1:0] lattr_rd_r;
  logic [SYM_W-1:0]  key_rd_r;
  logic [LOC_W-1:0]  sloc_rd_r;

  logic [LOC_W-1:0]    clr_cnt_r;
  logic [FILL_W-1:0]   fill_r, scan_idx_r;
  logic                found_r;
  status_t             status_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic [LOC_W-1:0]  in_loc;
  logic [ATTR_W-1:0] attrs;
  logic              sym_ok, flag_ok;
  logic              early_done;
  status_t           early_code;
  logic [SLOT_W-1:0] n_use;
  logic              hit_any;
  logic [SLOT_W-1:0] hit_idx;
  logic              all_res;

  assign in_loc = in_tdata[LOC_W-1:0];
  assign attrs  = {cat_r, fin_r, lot_r, flag_r == CHAR_Y};
  assign n_use  = (count_r > SLOT_W'(SLOTS)) ? SLOT_W'(SLOTS) : count_r;

  always_comb begin
    sym_ok = (sym_r[SYM_W-1 -: 8] != PAD_BYTE);
    for (int i = 0; i < SYM_W / 8; i++) begin
      if (sym_r[8*i +: 8] < PAD_BYTE || sym_r[8*i +: 8] > TOP_PRINT) sym_ok = 1'b0;
    end
  end

  assign flag_ok = (flag_r == CHAR_Y) || (flag_r == CHAR_N);

  always_comb begin
    early_done = 1'b1;
    if (loc_r == '0)     early_code = ST_RESERVED;
    else if (!sym_ok)    early_code = ST_BAD_SYM;
    else if (!flag_ok)   early_code = ST_BAD_FLAG;
    else if (known_rd_r) early_code = (lsym_rd_r != sym_r || lattr_rd_r != attrs) ?
                                      ST_LOC_CONFLICT : ST_REPEAT;
    else begin
      early_code = ST_NEW;
      early_done = 1'b0;
    end
  end

  // lowest requested slot in use that matches the symbol
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (SLOT_W'(i) < n_use && req_r[i] == sym_r) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    all_res = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (SLOT_W'(i) < n_use && !resolved_r[i]) all_res = 1'b0;
    end
  end

  assign stat.early_done  = early_done;
  assign stat.clr_last    = &clr_cnt_r;
  assign stat.scan_end    = scan_idx_r >= fill_r;
  assign stat.scan_hit    = key_rd_r == sym_r;
  assign stat.scan_loc_eq = sloc_rd_r == loc_r;
  assign stat.full_block  = !found_r && (fill_r == FILL_W'(SYMTAB_DEPTH));
  assign stat.out_free    = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      loc_r  <= in_loc;
      sym_r  <= in_tdata[LOC_W +: SYM_W];
      cat_r  <= in_tdata[LOC_W+SYM_W +: CAT_W];
      fin_r  <= in_tdata[LOC_W+SYM_W+CAT_W +: CAT_W];
      lot_r  <= in_tdata[LOC_W+SYM_W+2*CAT_W +: LOT_W];
      flag_r <= in_tdata[LOC_W+SYM_W+2*CAT_W+LOT_W +: CAT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) known_mem[clr_cnt_r] <= 1'b0;
    else if (cmd.commit) known_mem[loc_r] <= 1'b1;
    if (cmd.capture) known_rd_r <= known_mem[in_loc];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      lsym_mem[loc_r]  <= sym_r;
      lattr_mem[loc_r] <= attrs;
    end
    if (cmd.capture) begin
      lsym_rd_r  <= lsym_mem[in_loc];
      lattr_rd_r <= lattr_mem[in_loc];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !found_r) begin
      key_mem[fill_r[SYMTAB_AW-1:0]]  <= sym_r;
      sloc_mem[fill_r[SYMTAB_AW-1:0]] <= loc_r;
    end
    if (cmd.scan_rd) begin
      key_rd_r  <= key_mem[scan_idx_r[SYMTAB_AW-1:0]];
      sloc_rd_r <= sloc_mem[scan_idx_r[SYMTAB_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      fill_r     <= '0;
      scan_idx_r <= '0;
      found_r    <= 1'b0;
      resolved_r <= '0;
      count_r    <= '0;
      for (int i = 0; i < SLOTS; i++) req_r[i] <= '0;
      out_valid_r <= 1'b0;
      status_r   <= ST_NEW;
      slot_r     <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_we) begin
        if (cfg_addr == REG_COUNT) count_r <= cfg_wdata[SLOT_W-1:0];
        for (int i = 0; i < SLOTS; i++) begin
          if (cfg_addr == REG_SYM0 + CFG_AW'(i)) req_r[i] <= cfg_wdata;
        end
      end
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end
      if (cmd.scan_next) scan_idx_r <= scan_idx_r + 1'b1;
      if (cmd.scan_found) found_r <= 1'b1;
      if (cmd.take_early) begin
        status_r <= early_code;
        slot_r   <= '0;
      end
      if (cmd.take_conflict) begin
        status_r <= ST_SYM_CONFLICT;
        slot_r   <= '0;
      end
      if (cmd.take_full) begin
        status_r <= ST_FULL;
        slot_r   <= '0;
      end
      if (cmd.commit) begin
        if (!found_r) fill_r <= fill_r + 1'b1;
        if (hit_any && !resolved_r[hit_idx]) begin
          resolved_r[hit_idx] <= 1'b1;
          status_r <= ST_SELECTED;
          slot_r   <= hit_idx + 1'b1;
        end else begin
          status_r <= ST_NEW;
          slot_r   <= '0;
        end
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_data_r <= {all_res, slot_r, status_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/msdr_checker.sv =====
// port-level checks of the stock-directory resolver, bound to the top level
// depends on msdr_pkg and market_symbol_directory_resolver
module msdr_checker import msdr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_tready)
    else $error("beat offered right after reset");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on two cycles in a row");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_slot_iff_selected: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[6:4] != 3'd0) == (out_tdata[3:0] == ST_SELECTED)))
    else $error("resolved slot does not match status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= ST_FULL && out_tdata[6:4] <= 3'(SLOTS))
    else $error("result code out of range");

endmodule

bind market_symbol_directory_resolver msdr_checker u_msdr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/market_symbol_directory_resolver_tb.sv =====
// self-checking bench for the stock-directory resolver
// depends on msdr_pkg and market_symbol_directory_resolver; typed rows, then random records
// every result beat is checked field by field against a typed or in-bench predicted verdict
`timescale 1ns / 1ps

module market_symbol_directory_resolver_tb;
  import msdr_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [7:0]  flag;
    logic [31:0] lot;
    logic [7:0]  fin;
    logic [7:0]  cat;
    logic [63:0] sym;
    logic [15:0] loc;
  } dir_rec_t;

  typedef struct packed {
    logic    all;
    logic [2:0] slot;
    status_t st;
  } verdict_t;

  typedef struct {
    dir_rec_t rec;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;   // locate, symbol, category, status, lot, flag
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;       // status, resolved_slot, all_resolved
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  market_symbol_directory_resolver dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block's state
  logic [2:0]  req_count;
  logic [63:0] req_sym [SLOTS];
  bit          slot_done [SLOTS];
  logic [63:0] id_sym [int];
  logic [48:0] id_attr [int];
  int          known_locs [$];
  logic [63:0] tab_sym [$];
  logic [15:0] tab_loc [$];

  verdict_t pending [$];
  int       errors = 0;
  int       cycles = 0;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;
  bit       hold_go = 1'b0;
  int       hold_cnt = 0;

  function automatic bit sym_printable(logic [63:0] s);
    if (s[63:56] == PAD_BYTE) return 1'b0;
    for (int i = 0; i < 8; i++)
      if (s[8*i +: 8] < PAD_BYTE || s[8*i +: 8] > TOP_PRINT) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit every_slot_done();
    int n;
    n = (req_count > SLOTS) ? SLOTS : req_count;
    for (int i = 0; i < n; i++)
      if (!slot_done[i]) return 1'b0;
    return 1'b1;
  endfunction

  // works out the verdict for one record and updates the directory copy
  function automatic verdict_t resolve_record(dir_rec_t r);
    verdict_t v;
    logic [48:0] attrs;
    int hit;
    int n;
    v.st = ST_NEW;
    v.slot = 3'd0;
    attrs = {r.cat, r.fin, r.lot, r.flag == CHAR_Y};
    hit = -1;
    n = (req_count > SLOTS) ? SLOTS : req_count;
    if (r.loc == 0) v.st = ST_RESERVED;
    else if (!sym_printable(r.sym)) v.st = ST_BAD_SYM;
    else if (r.flag != CHAR_Y && r.flag != CHAR_N) v.st = ST_BAD_FLAG;
    else if (id_sym.exists(r.loc)) begin
      v.st = (id_sym[r.loc] != r.sym || id_attr[r.loc] != attrs) ? ST_LOC_CONFLICT : ST_REPEAT;
    end else begin
      foreach (tab_sym[i])
        if (hit < 0 && tab_sym[i] == r.sym) hit = i;
      if (hit >= 0 && tab_loc[hit] != r.loc) v.st = ST_SYM_CONFLICT;
      else if (hit < 0 && tab_sym.size() >= SYMTAB_DEPTH) v.st = ST_FULL;
      else begin
        id_sym[r.loc] = r.sym;
        id_attr[r.loc] = attrs;
        known_locs.insert(known_locs.size(), int'(r.loc));
        if (hit < 0) begin
          tab_sym.insert(tab_sym.size(), r.sym);
          tab_loc.insert(tab_loc.size(), r.loc);
        end
        // lowest matching slot decides, resolved or not
        for (int i = 0; i < n; i++)
          if (v.st == ST_NEW && req_sym[i] == r.sym) begin
            if (!slot_done[i]) begin
              slot_done[i] = 1'b1;
              v.st = ST_SELECTED;
              v.slot = 3'(i + 1);
            end
            break;
          end
      end
    end
    v.all = every_slot_done();
    return v;
  endfunction

  function automatic logic [63:0] fresh_symbol();
    logic [63:0] s;
    int len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < 8; i++)
      s[63 - 8*i -: 8] = (i < len) ? 8'($urandom_range(8'h21, TOP_PRINT)) : PAD_BYTE;
    return s;
  endfunction

  function automatic logic [15:0] fresh_locate();
    logic [15:0] l;
    for (int k = 0; k < 50; k++) begin
      l = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 2000));
      if (!id_sym.exists(l)) break;
    end
    return l;
  endfunction

  // mostly well-formed records with random content, some broken ones
  function automatic dir_rec_t random_record();
    dir_rec_t r;
    int pick;
    int l;
    r.cat = 8'($urandom);
    r.fin = 8'($urandom);
    r.lot = $urandom;
    r.flag = $urandom_range(0, 1) ? CHAR_Y : CHAR_N;
    r.loc = fresh_locate();
    r.sym = fresh_symbol();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
    end else if (pick < 45) begin
      r.sym = req_sym[$urandom_range(0, SLOTS - 1)];
    end else if (pick < 78 && known_locs.size() > 0) begin
      l = known_locs[$urandom_range(0, known_locs.size() - 1)];
      r.loc = 16'(l);
      r.sym = id_sym[l];
      {r.cat, r.fin, r.lot} = id_attr[l][48:1];
      r.flag = id_attr[l][0] ? CHAR_Y : CHAR_N;
      // a quarter of the known-locate records contradict the stored identity
      if (pick >= 70)
        case ($urandom_range(0, 4))
          0: r.sym = fresh_symbol();
          1: r.cat ^= 8'h01 << $urandom_range(0, 7);
          2: r.fin ^= 8'h01 << $urandom_range(0, 7);
          3: r.lot ^= 32'h1 << $urandom_range(0, 31);
          default: r.flag = (r.flag == CHAR_Y) ? CHAR_N : CHAR_Y;
        endcase
    end else if (pick < 85 && tab_sym.size() > 0) begin
      r.sym = tab_sym[$urandom_range(0, tab_sym.size() - 1)];
    end else begin
      case ($urandom_range(0, 3))
        0: r.loc = 16'd0;
        1: r.sym = {$urandom, $urandom};
        2: r.flag = 8'($urandom);
        default: r = {$urandom, $urandom, $urandom, $urandom, 8'($urandom)};
      endcase
    end
    return r;
  endfunction

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_COUNT) req_count = val[2:0];
    else if (idx <= SLOTS) req_sym[idx - 1] = val;
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
  endtask

  // drive one beat, hold it until the block takes it, then queue its verdict
  task automatic send_record(input dir_rec_t r, input bit typed, input verdict_t want);
    verdict_t v;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = resolve_record(r);
    pending.insert(pending.size(), typed ? want : v);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // long receiver hold-off, counted on its own
  always @(posedge clk)
    if (hold_go && hold_cnt < 600) hold_cnt <= hold_cnt + 1;

  // result side, with random stall
  always @(posedge clk) begin
    verdict_t got;
    verdict_t exp;
    cycles <= cycles + 1;
    if (hold_go && hold_cnt < 600) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        exp = pending.pop_front();
        if (got.st !== exp.st) begin
          $error("status expected %0d got %0d", exp.st, got.st);
          errors++;
        end
        if (got.slot !== exp.slot) begin
          $error("resolved_slot expected %0d got %0d", exp.slot, got.slot);
          errors++;
        end
        if (got.all !== exp.all) begin
          $error("all_resolved expected %0d got %0d", exp.all, got.all);
          errors++;
        end
      end
    end
  end

  always @(posedge clk)
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end

  localparam logic [63:0] SYM_A = "ABCD    ";
  localparam logic [63:0] SYM_Z = "ZZ      ";
  localparam verdict_t    NONE  = '0;

  function automatic verdict_t vd(status_t s, int slot, bit all);
    verdict_t v;
    v.st = s;
    v.slot = 3'(slot);
    v.all = all;
    return v;
  endfunction

  function automatic dir_rec_t rc(int loc, logic [63:0] sym, int cat,
                                  int fin, int lot, logic [7:0] flag);
    return {flag, 32'(lot), 8'(fin), 8'(cat), sym, 16'(loc)};
  endfunction

  dir_row_t rows [$];

  function automatic void add_row(dir_rec_t rec, bit typed, verdict_t want);
    dir_row_t row;
    row.rec = rec;
    row.typed = typed;
    row.want = want;
    rows.insert(rows.size(), row);
  endfunction

  initial begin
    req_count = 0;
    foreach (req_sym[i]) req_sym[i] = '0;
    foreach (slot_done[i]) slot_done[i] = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // writes are taken during the clearing pass as well
    cfg_write(REG_COUNT, 64'd2);
    cfg_write(REG_SYM0, SYM_A);
    cfg_write(REG_SYM0 + 3'd1, SYM_Z);
    cfg_done();

    // directed rows: check order, extremes, every status the fields can reach
    add_row(rc(0, SYM_A, 'h41, 'h4e, 100, CHAR_Y), 1, vd(ST_RESERVED, 0, 0));
    add_row(rc('hffff, "~~~~~~~~", 'hff, 'hff, 'hffffffff, CHAR_Y), 0, NONE);
    add_row(rc(5, " ABC    ", 1, 2, 3, CHAR_N), 1, vd(ST_BAD_SYM, 0, 0));
    add_row(rc(5, 64'h41424344_4546477f, 1, 2, 3, CHAR_N), 1, vd(ST_BAD_SYM, 0, 0));
    add_row(rc(5, 64'h41424344_4546471f, 1, 2, 3, CHAR_N), 1, vd(ST_BAD_SYM, 0, 0));
    add_row(rc(5, 64'h0, 1, 2, 3, CHAR_N), 1, vd(ST_BAD_SYM, 0, 0));
    add_row(rc(5, 64'hffffffff_ffffffff, 1, 2, 3, CHAR_N), 1, vd(ST_BAD_SYM, 0, 0));
    add_row(rc(5, "QQ      ", 1, 2, 3, "y"), 1, vd(ST_BAD_FLAG, 0, 0));
    add_row(rc(5, "QQ      ", 1, 2, 3, 8'hff), 1, vd(ST_BAD_FLAG, 0, 0));
    add_row(rc(1, SYM_A, 0, 0, 0, CHAR_N), 1, vd(ST_SELECTED, 1, 0));
    add_row(rc(1, SYM_A, 0, 0, 0, CHAR_N), 1, vd(ST_REPEAT, 0, 0));
    add_row(rc(1, SYM_A, 0, 0, 1, CHAR_N), 1, vd(ST_LOC_CONFLICT, 0, 0));
    add_row(rc(1, SYM_A, 0, 0, 0, CHAR_Y), 1, vd(ST_LOC_CONFLICT, 0, 0));
    add_row(rc(2, SYM_A, 0, 0, 0, CHAR_N), 1, vd(ST_SYM_CONFLICT, 0, 0));
    add_row(rc(3, SYM_Z, 'h51, 'h20, 100, CHAR_Y), 1, vd(ST_SELECTED, 2, 1));
    add_row(rc(3, SYM_Z, 'h52, 'h20, 100, CHAR_Y), 1, vd(ST_LOC_CONFLICT, 0, 1));
    add_row(rc(3, SYM_A, 'h51, 'h20, 100, CHAR_Y), 1, vd(ST_LOC_CONFLICT, 0, 1));
    add_row(rc(4, "!       ", 0, 0, 0, CHAR_N), 0, NONE);
    add_row(rc(7, "~       ", 'h80, 'h7f, 'h80000000, CHAR_Y), 0, NONE);
    add_row(rc(0, " bad    ", 0, 0, 0, 8'h00), 1, vd(ST_RESERVED, 0, 1));
    add_row(rc(6, " bad    ", 0, 0, 0, 8'h00), 1, vd(ST_BAD_SYM, 0, 1));
    add_row(rc('hffff, "~~~~~~~~", 'hff, 'hff, 'hffffffff, CHAR_Y), 0, NONE);
    foreach (rows[i]) send_record(rows[i].rec, rows[i].typed, rows[i].want);
    drain();

    // random phases, each with its own register setting and idle pattern
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          // slot 1 was resolved: its new symbol can only give new-unrequested
          cfg_write(REG_COUNT, 64'd6);
          for (int i = 0; i < SLOTS; i++) cfg_write(REG_SYM0 + CFG_AW'(i), fresh_symbol());
          cfg_write(REG_SYM0 + 3'd3, req_sym[2]);  // duplicate pair
          tx_idle_pct = 76; rx_stall_pct = 0;
        end
        1: begin
          cfg_write(REG_COUNT, 64'd7);  // above the slot count
          for (int i = 0; i < SLOTS; i++) cfg_write(REG_SYM0 + CFG_AW'(i), fresh_symbol());
          cfg_write(REG_SYM0 + 3'd5, 64'hffffffff_ffffffff);
          cfg_write(3'd7, 64'h5a5a5a5a_5a5a5a5a);  // no such register
          tx_idle_pct = 0; rx_stall_pct = 76;
        end
        2: begin
          cfg_write(REG_COUNT, 64'd0);
          tx_idle_pct = 13; rx_stall_pct = 13;
        end
        3: begin
          cfg_write(REG_COUNT, 64'd3);
          for (int i = 0; i < 3; i++) cfg_write(REG_SYM0 + CFG_AW'(i), fresh_symbol());
          tx_idle_pct = 0; rx_stall_pct = 0;
          hold_go = 1'b1;  // long receiver hold-off while records keep coming
        end
        default: begin
          cfg_write(REG_COUNT, 64'd6);
          for (int i = 0; i < SLOTS; i++) cfg_write(REG_SYM0 + CFG_AW'(i), fresh_symbol());
          cfg_write(REG_SYM0 + 3'd4, 64'd0);
          tx_idle_pct = 76; rx_stall_pct = 76;
        end
      endcase
      cfg_done();
      for (int k = 0; k < 136; k++) send_record(random_record(), 0, NONE);
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/msdr_pkg.sv
design/msdr_ctrl.sv
design/msdr_datapath.sv
design/market_symbol_directory_resolver.sv
design/msdr_checker.sv
bench/market_symbol_directory_resolver_tb.sv
